FILE: rtl/ttam_pkg.sv
// Shared constants and types for the touch tap affine mapper.
`timescale 1ns / 1ps
`default_nettype none

package ttam_pkg;

    localparam int DEF_PANEL_WIDTH  = 240;
    localparam int DEF_PANEL_HEIGHT = 320;
    localparam int DEF_CORNER_COUNT = 4;

    localparam int SAMPLE_W = 12;
    localparam int COEF_W   = 32;
    localparam int PRESS_W  = 13;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
    localparam int ACC_W    = PROD_W + 2;
    localparam int PIX_W    = 12;

    localparam logic [PRESS_W-1:0] ADC_FULL = PRESS_W'(4095);

    localparam logic [COEF_W-1:0] Q_ONE = COEF_W'(65536);

    localparam logic [2:0] REG_COEF_A    = 3'd0;
    localparam logic [2:0] REG_COEF_B    = 3'd1;
    localparam logic [2:0] REG_COEF_C    = 3'd2;
    localparam logic [2:0] REG_COEF_D    = 3'd3;
    localparam logic [2:0] REG_COEF_E    = 3'd4;
    localparam logic [2:0] REG_COEF_F    = 3'd5;
    localparam logic [2:0] REG_THRESHOLD = 3'd6;
    localparam logic [2:0] REG_CAPTURE   = 3'd7;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_TAP    = 2'd1,
        EV_CORNER = 2'd2
    } t_event;

    typedef logic signed [PROD_W-1:0] t_prod;

endpackage

`default_nettype wire

FILE: rtl/touch_tap_affine_mapper_unit.sv
// Top level of the touch tap affine mapper: sample pipeline, state and config registers.
// Pipeline: a sample word passes through the sample, product and result registers in turn.
// Throughput: one sample word per cycle while the output is taken; the four coefficient products sit in
// their own register stage ahead of the sum and clamp stage.
// Reset: synchronous, active low; coefficients return to identity, threshold and
// mode to zero, press history and corner count cleared, pipeline emptied.
`timescale 1ns / 1ps
`default_nettype none

module touch_tap_affine_mapper_unit #(
    parameter int PANEL_WIDTH  = ttam_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = ttam_pkg::DEF_PANEL_HEIGHT,
    parameter int CORNER_COUNT = ttam_pkg::DEF_CORNER_COUNT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,

    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [11:0] i_z1_sample,
    input  wire logic [11:0] i_z2_sample,
    input  wire logic [11:0] i_raw_x,
    input  wire logic [11:0] i_raw_y,

    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic [1:0]  o_event_kind,
    output      logic [7:0]  o_pixel_x,
    output      logic [8:0]  o_pixel_y,
    output      logic [1:0]  o_corner_index,
    output      logic [11:0] o_captured_x,
    output      logic [11:0] o_captured_y,
    output      logic        o_is_pressed,
    output      logic [12:0] o_pressure
);
    import ttam_pkg::*;

    localparam int CNT_W = $clog2(CORNER_COUNT + 1);

    // configuration
    logic signed [COEF_W-1:0] r_coef_a, r_coef_b, r_coef_c;
    logic signed [COEF_W-1:0] r_coef_d, r_coef_e, r_coef_f;
    logic [PRESS_W-1:0]       r_threshold;
    logic                     r_capture_mode;

    // block state
    logic                     r_pressed_before;
    logic [CNT_W-1:0]         r_corners;

    // sample stage
    logic                     r_s1_vld;
    logic [SAMPLE_W-1:0]      r_s1_z1, r_s1_z2, r_s1_rx, r_s1_ry;

    // product stage
    logic                     r_s2_vld;
    t_event                   r_s2_kind;
    logic [1:0]               r_s2_ci;
    logic [SAMPLE_W-1:0]      r_s2_cx, r_s2_cy;
    logic                     r_s2_pressed;
    logic [PRESS_W-1:0]       r_s2_pressure;
    t_prod                    r_s2_pax, r_s2_pby, r_s2_pdx, r_s2_pey;

    // result stage
    logic                     r_out_vld;
    t_event                   r_out_kind;
    logic [1:0]               r_out_ci;
    logic [SAMPLE_W-1:0]      r_out_cx, r_out_cy;
    logic                     r_out_pressed;
    logic [PRESS_W-1:0]       r_out_pressure;
    logic [PIX_W-1:0]         pix_x, pix_y;

    logic                     in_acc, s1_move, out_load;
    logic [PRESS_W-1:0]       pressure;
    logic                     pressed, press_edge, room;
    t_event                   n_kind;
    logic signed [SAMPLE_W:0] rx_s, ry_s;

    assign out_load   = r_s2_vld && (!r_out_vld || i_out_ready);
    assign s1_move    = r_s1_vld && (!r_s2_vld || out_load);
    assign o_in_ready = !r_s1_vld || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;

    assign pressure   = PRESS_W'({1'b0, r_s1_z1}) + ADC_FULL - PRESS_W'({1'b0, r_s1_z2});
    assign pressed    = pressure > r_threshold;
    assign press_edge = pressed && !r_pressed_before;
    assign room       = r_corners < CNT_W'(CORNER_COUNT);
    assign rx_s       = $signed({1'b0, r_s1_rx});
    assign ry_s       = $signed({1'b0, r_s1_ry});

    always_comb begin
        priority if (!press_edge) begin
            n_kind = EV_NONE;
        end else if (!r_capture_mode) begin
            n_kind = EV_TAP;
        end else if (room) begin
            n_kind = EV_CORNER;
        end else begin
            n_kind = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a       <= $signed(Q_ONE);
            r_coef_b       <= '0;
            r_coef_c       <= '0;
            r_coef_d       <= '0;
            r_coef_e       <= $signed(Q_ONE);
            r_coef_f       <= '0;
            r_threshold    <= '0;
            r_capture_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_A:    r_coef_a       <= $signed(i_cfg_data);
                REG_COEF_B:    r_coef_b       <= $signed(i_cfg_data);
                REG_COEF_C:    r_coef_c       <= $signed(i_cfg_data);
                REG_COEF_D:    r_coef_d       <= $signed(i_cfg_data);
                REG_COEF_E:    r_coef_e       <= $signed(i_cfg_data);
                REG_COEF_F:    r_coef_f       <= $signed(i_cfg_data);
                REG_THRESHOLD: r_threshold    <= i_cfg_data[PRESS_W-1:0];
                REG_CAPTURE:   r_capture_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // corner count restarts on every mode write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_before <= 1'b0;
            r_corners        <= '0;
        end else begin
            if (s1_move) begin
                r_pressed_before <= pressed;
            end
            if (i_cfg_we && i_cfg_idx == REG_CAPTURE) begin
                r_corners <= '0;
            end else if (s1_move && n_kind == EV_CORNER) begin
                r_corners <= r_corners + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_s2_vld <= 1'b1;
            end else if (out_load) begin
                r_s2_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_z1 <= i_z1_sample;
            r_s1_z2 <= i_z2_sample;
            r_s1_rx <= i_raw_x;
            r_s1_ry <= i_raw_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_kind     <= n_kind;
            r_s2_ci       <= (n_kind == EV_CORNER) ? r_corners[1:0] : 2'd0;
            r_s2_cx       <= (n_kind == EV_CORNER) ? r_s1_rx : '0;
            r_s2_cy       <= (n_kind == EV_CORNER) ? r_s1_ry : '0;
            r_s2_pressed  <= pressed;
            r_s2_pressure <= pressure;
            r_s2_pax      <= PROD_W'(r_coef_a) * PROD_W'(rx_s);
            r_s2_pby      <= PROD_W'(r_coef_b) * PROD_W'(ry_s);
            r_s2_pdx      <= PROD_W'(r_coef_d) * PROD_W'(rx_s);
            r_s2_pey      <= PROD_W'(r_coef_e) * PROD_W'(ry_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind     <= r_s2_kind;
            r_out_ci       <= r_s2_ci;
            r_out_cx       <= r_s2_cx;
            r_out_cy       <= r_s2_cy;
            r_out_pressed  <= r_s2_pressed;
            r_out_pressure <= r_s2_pressure;
        end
    end

    ttam_axis_clamp #(
        .LIMIT (PANEL_WIDTH)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_load   (out_load),
        .i_tap    (r_s2_kind == EV_TAP),
        .i_prod_x (r_s2_pax),
        .i_prod_y (r_s2_pby),
        .i_offset (r_coef_c),
        .o_pixel  (pix_x)
    );

    ttam_axis_clamp #(
        .LIMIT (PANEL_HEIGHT)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_load   (out_load),
        .i_tap    (r_s2_kind == EV_TAP),
        .i_prod_x (r_s2_pdx),
        .i_prod_y (r_s2_pey),
        .i_offset (r_coef_f),
        .o_pixel  (pix_y)
    );

    assign o_out_valid    = r_out_vld;
    assign o_event_kind   = r_out_kind;
    assign o_pixel_x      = pix_x[7:0];
    assign o_pixel_y      = pix_y[8:0];
    assign o_corner_index = r_out_ci;
    assign o_captured_x   = r_out_cx;
    assign o_captured_y   = r_out_cy;
    assign o_is_pressed   = r_out_pressed;
    assign o_pressure     = r_out_pressure;

endmodule

`default_nettype wire

FILE: rtl/ttam_axis_clamp.sv
// One mapped axis: sum of products and offset, truncation and clamp to the panel.
`timescale 1ns / 1ps
`default_nettype none

module ttam_axis_clamp #(
    parameter int LIMIT = ttam_pkg::DEF_PANEL_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_load,
    input  wire logic                    i_tap,
    input  wire ttam_pkg::t_prod         i_prod_x,
    input  wire ttam_pkg::t_prod         i_prod_y,
    input  wire logic signed [31:0]      i_offset,
    output      logic [ttam_pkg::PIX_W-1:0] o_pixel
);
    import ttam_pkg::*;

    localparam int WHOLE_W = ACC_W - FRAC_W - 1;
    localparam logic [WHOLE_W-1:0] MAX_PIX = WHOLE_W'(LIMIT - 1);

    logic signed [ACC_W-1:0] acc;
    logic [WHOLE_W-1:0]      whole;
    logic [PIX_W-1:0]        r_pixel;
    logic [PIX_W-1:0]        n_pixel;

    assign acc   = ACC_W'(i_prod_x) + ACC_W'(i_prod_y) + ACC_W'(i_offset);
    assign whole = acc[ACC_W-2:FRAC_W];

    // non-taps and negative sums give zero; larger sums clamp to LIMIT-1
    always_comb begin
        if (!i_tap || acc[ACC_W-1]) begin
            n_pixel = '0;
        end else if (whole > MAX_PIX) begin
            n_pixel = MAX_PIX[PIX_W-1:0];
        end else begin
            n_pixel = whole[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

`default_nettype wire
